// File: sv/escaped_word_frame_encoder_core_assert.svh
// Assertion macros for the escaped word frame encoder.
// Included by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef ESCAPED_WORD_FRAME_ENCODER_CORE_ASSERT_SVH
`define ESCAPED_WORD_FRAME_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EWFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define EWFE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EWFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define EWFE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/ewfe_pkg.sv
// Shared types and constants for the escaped word frame encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ewfe_pkg;

  // frame limit and word counter
  localparam int MAX_WORDS = 1024;
  localparam int CNT_W     = $clog2(MAX_WORDS);

  // configuration registers
  localparam int          CFG_IDX_W   = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STUFF  = CFG_IDX_W'(1);
  localparam logic [7:0]  ESCAPE_RESET = 8'd36;
  localparam logic [7:0]  STUFF_RESET  = 8'hFF;

  // word queue between front and back; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int WORD_W  = 32;
  localparam int NBYTES  = WORD_W / 8;
  localparam int POS_W   = $clog2(NBYTES);

  // one classified word: trailer words carry zero data and no escape hits
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              trailer;
    logic [NBYTES-1:0] esc;     // bit i: byte at data[8*i +: 8] matches
  } entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage
`default_nettype wire

// File: sv/ewfe_front.sv
// Front end: accepts input words, tracks the frame word count and
// classifies each word into an entry_t. Depends on ewfe_pkg.
`default_nettype none
module ewfe_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [31:0]         s_tdata,
  input  logic [7:0]          escape_char,
  input  logic                q_full,
  output logic                push,
  output ewfe_pkg::entry_t    push_entry
);
  import ewfe_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_WORDS - 1);

  logic [CNT_W-1:0] word_count;
  logic             end_frame;

  assign s_tready  = !q_full;
  assign push      = s_tvalid && s_tready;
  assign end_frame = (s_tdata == '0) || (word_count >= CNT_LIMIT);

  always_comb begin
    push_entry.data    = end_frame ? '0 : s_tdata;
    push_entry.trailer = end_frame;
    for (int i = 0; i < NBYTES; i++) begin
      push_entry.esc[i] = !end_frame && (s_tdata[8*i +: 8] == escape_char);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (push) begin
      word_count <= end_frame ? '0 : word_count + 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/ewfe_queue.sv
// Short FIFO of classified words between the front and back ends.
// Depends on ewfe_pkg.
`default_nettype none
module ewfe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ewfe_pkg::entry_t push_entry,
  input  logic             pop,
  output ewfe_pkg::entry_t head,
  output ewfe_pkg::qstat_t stat
);
  import ewfe_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] cnt;

  assign head       = mem[rd_ptr];
  assign stat.valid = (cnt != '0);
  assign stat.full  = (cnt == QCNT_W'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/ewfe_back.sv
// Back end: walks one queued word byte by byte, inserting stuffing bytes,
// and drives the registered byte stream. Depends on ewfe_pkg.
`default_nettype none
module ewfe_back (
  input  logic             clk,
  input  logic             rst,
  input  ewfe_pkg::entry_t head,
  input  logic             q_valid,
  output logic             pop,
  input  logic [7:0]       stuff_byte,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);
  import ewfe_pkg::*;

  localparam logic [POS_W-1:0] POS_FIRST = POS_W'(NBYTES - 1);

  entry_t           cur;
  logic             busy;
  logic [POS_W-1:0] pos;
  logic             stuff_pend;
  logic             load;
  logic             step;
  logic             emit_last;
  logic [7:0]       emit_byte;

  assign load      = !m_tvalid || m_tready;
  assign step      = busy && load;
  assign emit_last = (pos == '0) && (stuff_pend || !cur.esc[pos]);
  assign emit_byte = stuff_pend ? stuff_byte : cur.data[{pos, 3'b000} +: 8];
  // take the next word as the current one sends its last byte
  assign pop       = q_valid && (!busy || (step && emit_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      stuff_pend <= 1'b0;
      pos        <= POS_FIRST;
      m_tvalid   <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= busy;
      end
      if (pop) begin
        busy       <= 1'b1;
        stuff_pend <= 1'b0;
        pos        <= POS_FIRST;
      end else if (step) begin
        if (!stuff_pend && cur.esc[pos]) begin
          stuff_pend <= 1'b1;
        end else begin
          stuff_pend <= 1'b0;
          pos        <= pos - 1'b1;
          if (emit_last) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (step) begin
      m_tdata <= emit_byte;
      m_tuser <= emit_last;
      m_tlast <= emit_last && cur.trailer;
    end
  end

endmodule
`default_nettype wire

// File: sv/escaped_word_frame_encoder_core.sv
// Top level of the escaped word frame encoder: configuration registers,
// front end, word queue and back end. Depends on ewfe_pkg and the assert header.
`default_nettype none
// Byte-stuffing frame encoder. Each 32-bit word on the slave stream is sent
// on the master stream most significant byte first, one byte per clock while
// m_tready allows; a stuffing byte follows every data byte equal to the escape
// character. A zero word, or a word arriving once MAX_WORDS - 1 words have
// been sent in the frame, is not sent: four zero bytes go out instead, the
// last with tlast high, and the count restarts. tuser marks the last byte
// caused by each word. A word yields 4 to 8 bytes (4 plus one per escape
// match, 4 for a frame end), sequenced by the back end. Words enter a
// two-deep queue, so the input accepts new words while the output stalls,
// until the queue is full.
module escaped_word_frame_encoder_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // word_in[31:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // out_byte[7:0]
  output logic                               m_tuser,   // item_done
  output logic                               m_tlast,   // frame_done
  input  logic                               cfg_we,
  input  logic [ewfe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_wdata
);
  import ewfe_pkg::*;

  logic [7:0] escape_char;
  logic [7:0] stuff_byte;
  entry_t     push_entry;
  entry_t     head;
  qstat_t     qstat;
  logic       push;
  logic       pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_char <= ESCAPE_RESET;
      stuff_byte  <= STUFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ESCAPE: escape_char <= cfg_wdata;
        REG_STUFF:  stuff_byte  <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  ewfe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .escape_char (escape_char),
    .q_full      (qstat.full),
    .push        (push),
    .push_entry  (push_entry)
  );

  ewfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  ewfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_valid    (qstat.valid),
    .pop        (pop),
    .stuff_byte (stuff_byte),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

`include "escaped_word_frame_encoder_core_assert.svh"

  `EWFE_ASSERT_IMP(a_last_is_item_end, clk, rst, m_tvalid && m_tlast, m_tuser, "frame end without word end")
  `EWFE_ASSERT_IMP(a_trailer_zero, clk, rst, m_tvalid && m_tlast, m_tdata == 8'h00, "trailer byte not zero")
  `EWFE_ASSERT_NXT(a_push_queued, clk, rst, s_tvalid && s_tready, qstat.valid, "accepted word lost from queue")

endmodule
`default_nettype wire

// File: tb/tb_escaped_word_frame_encoder_core.sv
// Self-checking testbench for escaped_word_frame_encoder_core: drives words on the
// slave stream and checks every byte on the master stream against an in-bench encoder.
// Depends on ewfe_pkg and the core RTL only.
module tb_escaped_word_frame_encoder_core;
  import ewfe_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [7:0] data;
    logic       item_done;
    logic       frame_done;
  } enc_byte_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [31:0]          s_tdata;   // word_in[31:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [7:0]           m_tdata;   // out_byte[7:0]
  logic                 m_tuser;   // item_done
  logic                 m_tlast;   // frame_done
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  escaped_word_frame_encoder_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // encoder mirror state
  logic [7:0]  enc_escape;
  logic [7:0]  enc_stuff;
  int unsigned words_in_frame;
  enc_byte_t   bytes_due[$];

  int    mismatches;
  int    cycle_cnt;
  bit    tx_idle_on;
  bit    rx_idle_on;
  int    rx_hold_req;
  int    rx_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Expected bytes for one accepted word.
  function automatic void encode_word(logic [31:0] w);
    enc_byte_t b;
    if (w == 32'd0 || words_in_frame >= MAX_WORDS - 1) begin
      for (int i = 0; i < 4; i++) begin
        b.data       = 8'd0;
        b.item_done  = (i == 3);
        b.frame_done = (i == 3);
        bytes_due.push_back(b);
      end
      words_in_frame = 0;
      return;
    end
    for (int s = 3; s >= 0; s--) begin
      b.data       = w[8*s +: 8];
      b.item_done  = 1'b0;
      b.frame_done = 1'b0;
      bytes_due.push_back(b);
      if (w[8*s +: 8] == enc_escape) begin
        b.data = enc_stuff;
        bytes_due.push_back(b);
      end
    end
    bytes_due[bytes_due.size()-1].item_done = 1'b1;
    words_in_frame++;
  endfunction

  // Receiver: long hold-off on request, otherwise random stalls when idling is on.
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      m_tready <= 1'b0;
      rx_hold_req--;
    end else if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_tready <= 1'b1;
      if (rx_idle_on) rx_stall = pick_gap();
    end
  end

  // Byte checker
  always @(posedge clk) begin
    enc_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected byte: data=%02h item_done=%0b frame_done=%0b",
                   m_tdata, m_tuser, m_tlast);
      end else begin
        want = bytes_due.pop_front();
        if (m_tdata !== want.data || m_tuser !== want.item_done ||
            m_tlast !== want.frame_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("byte mismatch: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                     want.data, want.item_done, want.frame_done,
                     m_tdata, m_tuser, m_tlast);
        end
      end
    end
  end

  // Offer one word after an optional gap; predict on acceptance.
  task automatic send_word(logic [31:0] w);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    encode_word(w);
  endtask

  // Stop offering and wait until every expected byte has come out.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_ESCAPE) enc_escape = val;
    else if (idx == REG_STUFF) enc_stuff = val;
  endtask

  // Bytes biased toward the escape character and zero.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    int          r;
    if ($urandom_range(0, 99) < 5) return 32'd0;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) w[8*i +: 8] = enc_escape;
      else if (r < 38) w[8*i +: 8] = 8'd0;
      else w[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  task automatic test_default_config();
    send_word(32'h24242424);
    send_word(32'h00000000);
    send_word(32'hFFFFFFFF);
    send_word(32'h00000001);
    send_word(32'h24000000);
    send_word(32'h80000000);
    send_word(32'h7FFFFFFF);
    send_word(32'h00000024);
    send_word(32'hA5A5A5A5);
    send_word(32'h00000000);
    drain();
  endtask

  // Zero as escape: trailer zeros must still go out unstuffed; also 0xFF as escape.
  task automatic test_config_extremes();
    write_reg(REG_ESCAPE, 8'h00);
    write_reg(REG_STUFF, 8'h00);
    send_word(32'h00FF0000);
    send_word(32'h00000000);
    send_word(32'h01000000);
    send_word(32'h00000000);
    drain();
    write_reg(REG_ESCAPE, 8'hFF);
    write_reg(REG_STUFF, 8'h00);
    send_word(32'hFFFFFFFF);
    send_word(32'hFF00FF00);
    send_word(32'h000000FF);
    send_word(32'h00000000);
    drain();
    write_reg(REG_ESCAPE, 8'h00);
    write_reg(REG_STUFF, 8'hFF);
    send_word(32'h10000000);
    send_word(32'h00000000);
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(REG_ESCAPE, 8'h00);
          write_reg(REG_STUFF, 8'hFF);
        end
        1: begin
          write_reg(REG_ESCAPE, 8'hFF);
          write_reg(REG_STUFF, 8'h00);
        end
        default: begin
          write_reg(REG_ESCAPE, 8'($urandom_range(0, 255)));
          write_reg(REG_STUFF, 8'($urandom_range(0, 255)));
        end
      endcase
      // alternate stretches with and without idling
      tx_idle_on = (p != 2);
      rx_idle_on = (p != 3);
      repeat (48) send_word(rand_word());
      drain();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Hold the output off while words keep coming, so the input has to stall.
  task automatic test_backpressure();
    write_reg(REG_ESCAPE, 8'h24);
    write_reg(REG_STUFF, 8'hFF);
    tx_idle_on = 1'b0;
    @(negedge clk);
    rx_hold_req = 300;
    repeat (20) send_word(rand_word());
    tx_idle_on = 1'b1;
    drain();
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 32'd0;
    m_tready    = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_ESCAPE;
    cfg_wdata   = 8'd0;
    mismatches  = 0;
    cycle_cnt   = 0;
    rx_hold_req = 0;
    rx_stall    = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    enc_escape     = ESCAPE_RESET;
    enc_stuff      = STUFF_RESET;
    words_in_frame = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_config();
    test_config_extremes();
    test_random_phases();
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && bytes_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ewfe_pkg.sv
sv/ewfe_front.sv
sv/ewfe_queue.sv
sv/ewfe_back.sv
sv/escaped_word_frame_encoder_core.sv
tb/tb_escaped_word_frame_encoder_core.sv
